// ===== hdl/ell_pkg.sv =====
`default_nettype none
package ell_pkg;

    localparam int PosBitsDefault = 16;
    localparam int OutPosBits = 16;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_IDENT = 3'd1,
        MODE_INT   = 3'd2,
        MODE_OP    = 3'd3,
        MODE_STR   = 3'd4,
        MODE_ESC   = 3'd5,
        MODE_STOP  = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        REC_CHAR  = 2'd0,
        REC_DONE  = 2'd1,
        REC_ERROR = 2'd2
    } rec_type_t;

    localparam logic [1:0] ERR_UNRECOGNIZED = 2'd0;
    localparam logic [1:0] ERR_END_IN_STRING = 2'd1;
    localparam logic [1:0] ERR_BAD_ESCAPE = 2'd2;

    localparam logic [4:0] K_IDENT = 5'd0;
    localparam logic [4:0] K_INT = 5'd6;
    localparam logic [4:0] K_STR = 5'd7;
    localparam logic [4:0] K_NONE = 5'd31;

    // A classified record leaving the front part; positions are already clipped.
    typedef struct packed {
        rec_type_t   rtype;
        logic [7:0]  ch;
        logic [4:0]  kind;
        logic [15:0] line;
        logic [15:0] col;
        logic [1:0]  err;
        logic        last;
    } rec_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [3:0] kw_len(input logic [2:0] k);
        case (k)
            3'd0: return 4'd3;
            3'd1: return 4'd2;
            3'd2: return 4'd4;
            3'd3: return 4'd5;
            3'd4: return 4'd8;
            default: return 4'd0;
        endcase
    endfunction

    // Keyword text is right-aligned in the vector, so it is moved to the top first.
    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] i);
        logic [63:0] t;
        case (k)
            3'd0: t = "var";
            3'd1: t = "if";
            3'd2: t = "else";
            3'd3: t = "while";
            3'd4: t = "function";
            default: t = '0;
        endcase
        t = t << (8 * (8 - int'(kw_len(k))));
        return t[8*(7-i[2:0]) +: 8];
    endfunction

    function automatic logic [7:0] op_first(input logic [2:0] o);
        case (o)
            3'd0: return "=";
            3'd1: return "<";
            3'd2: return ">";
            3'd3: return "&";
            3'd4: return "|";
            3'd5: return "!";
            default: return 8'd0;
        endcase
    endfunction

    function automatic logic [7:0] op_second(input logic [2:0] o);
        case (o)
            3'd3: return "&";
            3'd4: return "|";
            default: return "=";
        endcase
    endfunction

    function automatic logic [4:0] op_one(input logic [2:0] o);
        case (o)
            3'd0: return 5'd18;
            3'd1: return 5'd20;
            3'd2: return 5'd22;
            default: return K_NONE;
        endcase
    endfunction

    function automatic logic [4:0] op_two(input logic [2:0] o);
        case (o)
            3'd0: return 5'd19;
            3'd1: return 5'd21;
            3'd2: return 5'd23;
            3'd3: return 5'd24;
            3'd4: return 5'd25;
            3'd5: return 5'd26;
            default: return 5'd19;
        endcase
    endfunction

    function automatic logic [4:0] single_kind(input logic [7:0] c);
        case (c)
            "+": return 5'd8;
            "-": return 5'd9;
            "*": return 5'd10;
            "/": return 5'd11;
            "(": return 5'd12;
            ")": return 5'd13;
            ";": return 5'd14;
            "{": return 5'd15;
            "}": return 5'd16;
            ",": return 5'd17;
            default: return K_NONE;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== hdl/ell_front.sv =====
`default_nettype none
module ell_front #(
    parameter int PosBits = ell_pkg::PosBitsDefault
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                kind,
    input  wire logic [7:0]          source_byte,
    output ell_pkg::rec_t [2:0]      recs,
    output logic [1:0]               rec_count
);
    import ell_pkg::*;

    localparam logic [PosBits-1:0] PosMax = '1;
    localparam logic [PosBits-1:0] PosOne = PosBits'(1);

    mode_t              mode_reg, mode_next;
    logic [2:0]         op_reg, op_next;
    logic [4:0]         kwm_reg, kwm_next;
    logic [3:0]         len_reg, len_next;
    logic [PosBits-1:0] line_reg, line_next, col_reg, col_next;
    logic [PosBits-1:0] tline_reg, tline_next, tcol_reg, tcol_next;

    function automatic logic [15:0] clip(input logic [PosBits-1:0] v);
        if (PosBits > OutPosBits && v > PosBits'(16'hFFFF))
            return 16'hFFFF;
        return 16'(v);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            op_reg    <= '0;
            kwm_reg   <= '0;
            len_reg   <= '0;
            line_reg  <= PosOne;
            col_reg   <= PosOne;
            tline_reg <= PosOne;
            tcol_reg  <= PosOne;
        end
        else if (in_valid)
        begin
            mode_reg  <= mode_next;
            op_reg    <= op_next;
            kwm_reg   <= kwm_next;
            len_reg   <= len_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            tline_reg <= tline_next;
            tcol_reg  <= tcol_next;
        end
    end

    always_comb
    begin
        logic [7:0]  c;
        logic [2:0]  op;
        logic [4:0]  kw_kind;
        logic [4:0]  keep;
        logic [4:0]  sk;
        logic        start;
        logic [15:0] pl, pc;
        logic [1:0]  n;
        rec_t        r;
        c = source_byte;
        op = (op_reg < 3'd6) ? op_reg : 3'd0;
        mode_next = mode_reg;
        op_next = op_reg;
        kwm_next = kwm_reg;
        len_next = len_reg;
        line_next = line_reg;
        col_next = col_reg;
        tline_next = tline_reg;
        tcol_next = tcol_reg;
        recs = '0;
        n = 2'd0;
        start = 1'b0;
        kw_kind = K_IDENT;
        for (int i = 4; i >= 0; i--)
        begin
            if (kwm_reg[i] && len_reg == kw_len(3'(i)))
                kw_kind = 5'(i + 1);
        end
        keep = '0;
        for (int i = 0; i < 5; i++)
        begin
            if (kwm_reg[i] && len_reg < kw_len(3'(i)) && kw_char(3'(i), len_reg) == c)
                keep[i] = 1'b1;
        end
        pl = clip(line_reg);
        pc = clip(col_reg);
        r = '0;
        if (mode_reg != MODE_STOP && mode_reg <= MODE_ESC)
        begin
            if (kind)
            begin
                r.line = pl;
                r.col = pc;
                r.rtype = REC_ERROR;
                case (mode_reg)
                    MODE_IDENT:
                    begin
                        r.rtype = REC_DONE; r.kind = kw_kind;
                        r.line = clip(tline_reg); r.col = clip(tcol_reg);
                        recs[0] = r; n = 2'd1;
                    end
                    MODE_INT:
                    begin
                        r.rtype = REC_DONE; r.kind = K_INT;
                        r.line = clip(tline_reg); r.col = clip(tcol_reg);
                        recs[0] = r; n = 2'd1;
                    end
                    MODE_OP:
                    begin
                        if (op_one(op) == K_NONE)
                        begin
                            r.err = ERR_UNRECOGNIZED;
                        end
                        else
                        begin
                            r.rtype = REC_DONE; r.kind = op_one(op);
                            r.line = clip(tline_reg); r.col = clip(tcol_reg);
                        end
                        recs[0] = r; n = 2'd1;
                    end
                    MODE_STR: begin r.err = ERR_END_IN_STRING; recs[0] = r; n = 2'd1; end
                    MODE_ESC: begin r.err = ERR_BAD_ESCAPE; recs[0] = r; n = 2'd1; end
                    default: n = 2'd0;
                endcase
                mode_next = MODE_STOP;
            end
            else
            begin
                if (c == 8'h0A)
                begin
                    col_next = PosOne;
                    if (line_reg < PosMax)
                        line_next = line_reg + PosOne;
                end
                else if (col_reg < PosMax)
                begin
                    col_next = col_reg + PosOne;
                end
                r.line = clip(tline_reg);
                r.col = clip(tcol_reg);
                case (mode_reg)
                    MODE_IDLE: start = 1'b1;
                    MODE_IDENT:
                    begin
                        if (is_alpha(c) || is_digit(c))
                        begin
                            kwm_next = keep;
                            if (len_reg != 4'd15)
                                len_next = len_reg + 4'd1;
                            r.rtype = REC_CHAR; r.ch = c; recs[0] = r; n = 2'd1;
                        end
                        else
                        begin
                            r.rtype = REC_DONE; r.kind = kw_kind; recs[0] = r; n = 2'd1;
                            start = 1'b1;
                        end
                    end
                    MODE_INT:
                    begin
                        if (is_digit(c))
                        begin
                            r.rtype = REC_CHAR; r.ch = c; recs[0] = r; n = 2'd1;
                        end
                        else
                        begin
                            r.rtype = REC_DONE; r.kind = K_INT; recs[0] = r; n = 2'd1;
                            start = 1'b1;
                        end
                    end
                    MODE_OP:
                    begin
                        if (c == op_second(op))
                        begin
                            r.rtype = REC_CHAR; r.ch = c; recs[0] = r;
                            r.rtype = REC_DONE; r.ch = '0; r.kind = op_two(op); recs[1] = r;
                            n = 2'd2;
                            mode_next = MODE_IDLE;
                        end
                        else if (op_one(op) == K_NONE)
                        begin
                            r.rtype = REC_ERROR; r.err = ERR_UNRECOGNIZED;
                            r.line = clip(line_next); r.col = clip(col_next);
                            recs[0] = r; n = 2'd1;
                            mode_next = MODE_STOP;
                        end
                        else
                        begin
                            r.rtype = REC_DONE; r.kind = op_one(op); recs[0] = r; n = 2'd1;
                            start = 1'b1;
                        end
                    end
                    MODE_STR:
                    begin
                        if (c == "\\")
                            mode_next = MODE_ESC;
                        else if (c == "\"")
                        begin
                            r.rtype = REC_DONE; r.kind = K_STR; recs[0] = r; n = 2'd1;
                            mode_next = MODE_IDLE;
                        end
                        else
                        begin
                            r.rtype = REC_CHAR; r.ch = c; recs[0] = r; n = 2'd1;
                        end
                    end
                    default:
                    begin
                        r.rtype = REC_CHAR;
                        mode_next = MODE_STR;
                        case (c)
                            "n": r.ch = 8'h0A;
                            "t": r.ch = 8'h09;
                            "r": r.ch = 8'h0D;
                            "\"": r.ch = c;
                            default:
                            begin
                                r.rtype = REC_ERROR; r.err = ERR_BAD_ESCAPE;
                                r.line = clip(line_next); r.col = clip(col_next);
                                mode_next = MODE_STOP;
                            end
                        endcase
                        recs[0] = r; n = 2'd1;
                    end
                endcase
                if (start)
                begin
                    mode_next = MODE_IDLE;
                    r = '0;
                    if (!is_space(c))
                    begin
                        tline_next = line_reg;
                        tcol_next = col_reg;
                        r.line = pl;
                        r.col = pc;
                        r.ch = c;
                        sk = single_kind(c);
                        if (is_alpha(c))
                        begin
                            kwm_next = 5'b11111 & {1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
                            for (int i = 0; i < 5; i++)
                                kwm_next[i] = (kw_char(3'(i), 4'd0) == c);
                            len_next = 4'd1;
                            recs[n] = r; n = n + 2'd1;
                            mode_next = MODE_IDENT;
                        end
                        else if (is_digit(c))
                        begin
                            recs[n] = r; n = n + 2'd1;
                            mode_next = MODE_INT;
                        end
                        else if (c == "\"")
                        begin
                            mode_next = MODE_STR;
                        end
                        else if (c == "=" || c == "<" || c == ">" || c == "&" || c == "|"
                                 || c == "!")
                        begin
                            for (int i = 0; i < 6; i++)
                                if (op_first(3'(i)) == c)
                                    op_next = 3'(i);
                            recs[n] = r; n = n + 2'd1;
                            mode_next = MODE_OP;
                        end
                        else if (sk != K_NONE)
                        begin
                            recs[n] = r;
                            r.rtype = REC_DONE; r.ch = '0; r.kind = sk;
                            recs[n + 2'd1] = r;
                            n = n + 2'd2;
                        end
                        else
                        begin
                            r.rtype = REC_ERROR; r.ch = '0; r.err = ERR_UNRECOGNIZED;
                            r.line = clip(line_next); r.col = clip(col_next);
                            recs[n] = r; n = n + 2'd1;
                            mode_next = MODE_STOP;
                        end
                    end
                end
            end
        end
        if (n != 2'd0)
            recs[n - 2'd1].last = 1'b1;
        rec_count = n;
    end
endmodule
`default_nettype wire

// ===== hdl/ell_queue.sv =====
`default_nettype none
module ell_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire ell_pkg::rec_t [2:0] wr_recs,
    input  wire logic [1:0]          wr_count,
    output logic                     can_take,
    output logic                     rd_valid,
    output ell_pkg::rec_t            rd_rec,
    input  wire logic                rd_en
);
    import ell_pkg::*;

    localparam int Depth = 8;

    rec_t       mem_reg [Depth];
    logic [2:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [1:0] n_in;
    logic       pop_ok;

    assign n_in = wr_en ? wr_count : 2'd0;
    assign pop_ok = rd_en && cnt_reg != 4'd0;
    assign can_take = cnt_reg <= 4'(Depth - 3);
    assign rd_valid = cnt_reg != 4'd0;
    assign rd_rec = mem_reg[rp_reg];
    assign wp_next = wp_reg + 3'(n_in);
    assign rp_next = rp_reg + 3'(pop_ok);
    assign cnt_next = cnt_reg + 4'(n_in) - 4'(pop_ok);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            if (2'(i) < n_in)
                mem_reg[wp_reg + 3'(i)] <= wr_recs[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 4'(Depth)) else $error("queue overflow");
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> cnt_reg == $past(cnt_reg) + 4'($past(n_in)) - 4'($past(pop_ok)))
        else $error("count mismatch");
    a_take_room: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> can_take) else $error("write without room");
endmodule
`default_nettype wire

// ===== hdl/expression_language_lexer_core.sv =====
// Streaming lexer: one byte or end-of-input mark is taken per cycle through
// push/full, and one result record per cycle leaves through pop/empty. The
// front part classifies each byte combinationally and writes up to three
// records into an eight-entry record queue; full rises while fewer than three
// entries are free, so input runs at one item per cycle while the reader keeps
// pace, and an error or end of input halts the block until reset.
`default_nettype none
module expression_language_lexer_core #(
    parameter int POSITION_BITS = ell_pkg::PosBitsDefault
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        kind,
    input  wire logic [7:0]  source_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       record_type,
    output logic [7:0]       char_value,
    output logic [4:0]       token_kind,
    output logic [15:0]      line_number,
    output logic [15:0]      column_number,
    output logic [1:0]       error_code,
    output logic             last
);
    import ell_pkg::*;

    rec_t [2:0] recs;
    logic [1:0] rec_count;
    logic       take, can_take, rd_valid;
    rec_t       rd_rec;

    assign take = push && can_take;
    assign full = !can_take;
    assign empty = !rd_valid;

    ell_front #(.PosBits(POSITION_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(take), .kind(kind),
        .source_byte(source_byte), .recs(recs), .rec_count(rec_count)
    );

    ell_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_en(take), .wr_recs(recs),
        .wr_count(rec_count), .can_take(can_take), .rd_valid(rd_valid),
        .rd_rec(rd_rec), .rd_en(pop)
    );

    assign record_type = rd_rec.rtype;
    assign char_value = rd_rec.ch;
    assign token_kind = rd_rec.kind;
    assign line_number = rd_rec.line;
    assign column_number = rd_rec.col;
    assign error_code = rd_rec.err;
    assign last = rd_rec.last;
endmodule
`default_nettype wire
